FILE: rtl/uer_pkg.sv
package uer_pkg;

	// Timer width used for the microsecond echo measurement.
	localparam int TIMER_WIDTH = 32;
	localparam logic [31:0] TIMER_MASK = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

	// Speed of sound scaling: distance = (width * 343 mod 2^32) / 2000.
	localparam logic [8:0] SOUND_NUM = 9'd343;

	// Division by 2000 is a shift by 4 followed by a reciprocal multiply for 125.
	localparam int DIV_SHIFT = 35;
	localparam logic [28:0] DIV_RECIP = 29'd274877907;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	// Request modes.
	localparam logic [2:0] MODE_TRIGGER = 3'd0;
	localparam logic [2:0] MODE_EDGE    = 3'd1;
	localparam logic [2:0] MODE_TICK    = 3'd2;
	localparam logic [2:0] MODE_READ    = 3'd3;
	localparam logic [2:0] MODE_CLEAR   = 3'd4;

	// Read status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_NO_DATA = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// One request as held in the input register.
	typedef struct packed {
		logic [2:0]  mode;
		logic        echo_level;
		logic [31:0] now_us;
		logic [31:0] now_ms;
	} req_t;

	// Result after the control stage, distance not yet divided.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] echo_time_us;
		logic [31:0] scaled;
		logic        wrapped;
		logic        trigger_pulse;
		logic        busy_flag;
		logic        ready_flag;
	} mid_t;

	// Final result.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] echo_time_us;
		logic [21:0] range_mm;
		logic        wrapped;
		logic        trigger_pulse;
		logic        busy_flag;
		logic        ready_flag;
	} res_t;

endpackage

FILE: rtl/uer_req_if.sv
interface uer_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic        echo_level;
	logic [31:0] now_us;
	logic [31:0] now_ms;

	modport source (output valid, mode, echo_level, now_us, now_ms, input ready);
	modport sink (input valid, mode, echo_level, now_us, now_ms, output ready);
endinterface

FILE: rtl/uer_res_if.sv
interface uer_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] echo_time_us;
	logic [21:0] range_mm;
	logic        wrapped;
	logic        trigger_pulse;
	logic        busy_flag;
	logic        ready_flag;

	modport source (output valid, status, echo_time_us, range_mm, wrapped,
		trigger_pulse, busy_flag, ready_flag, input ready);
	modport sink (input valid, status, echo_time_us, range_mm, wrapped,
		trigger_pulse, busy_flag, ready_flag, output ready);
endinterface

FILE: rtl/uer_ctrl.sv
module uer_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             item_valid,
	input  uer_pkg::req_t    item,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	output uer_pkg::mid_t    mid_s2
);

	logic [15:0] limit_q;
	logic [31:0] start_time_q;
	logic [31:0] pulse_width_q;
	logic [31:0] trigger_time_q;
	logic        measuring_q;
	logic        ready_q;
	logic        wrap_seen_q;
	logic        timed_out_q;

	logic [31:0] start_time_d;
	logic [31:0] pulse_width_d;
	logic [31:0] trigger_time_d;
	logic        measuring_d;
	logic        ready_d;
	logic        wrap_seen_d;
	logic        timed_out_d;
	logic [31:0] now_us;
	logic [31:0] elapsed_ms;
	logic [1:0]  status;
	logic        ok_read;
	logic        pulse;
	logic [40:0] product;

	assign now_us     = item.now_us & uer_pkg::TIMER_MASK;
	assign elapsed_ms = item.now_ms - trigger_time_q;
	assign product    = pulse_width_q * uer_pkg::SOUND_NUM;

	// Next state and result for the request in the input register.
	always_comb begin
		start_time_d   = start_time_q;
		pulse_width_d  = pulse_width_q;
		trigger_time_d = trigger_time_q;
		measuring_d    = measuring_q;
		ready_d        = ready_q;
		wrap_seen_d    = wrap_seen_q;
		timed_out_d    = timed_out_q;
		status         = uer_pkg::ST_OK;
		ok_read        = 1'b0;
		pulse          = 1'b0;
		unique case (item.mode)
			uer_pkg::MODE_TRIGGER: begin
				if (!measuring_q) begin
					start_time_d   = '0;
					pulse_width_d  = '0;
					ready_d        = 1'b0;
					wrap_seen_d    = 1'b0;
					timed_out_d    = 1'b0;
					measuring_d    = 1'b1;
					trigger_time_d = item.now_ms;
					pulse          = 1'b1;
				end
			end
			uer_pkg::MODE_EDGE: begin
				if (measuring_q) begin
					if (item.echo_level) begin
						start_time_d = now_us;
					end else begin
						if (now_us < start_time_q) begin
							wrap_seen_d = 1'b1;
						end
						pulse_width_d = (now_us - start_time_q) & uer_pkg::TIMER_MASK;
						ready_d       = 1'b1;
						measuring_d   = 1'b0;
					end
				end
			end
			uer_pkg::MODE_TICK: begin
				if (measuring_q && (elapsed_ms > {16'd0, limit_q})) begin
					timed_out_d = 1'b1;
					measuring_d = 1'b0;
				end
			end
			uer_pkg::MODE_READ: begin
				if (timed_out_q) begin
					timed_out_d = 1'b0;
					status      = uer_pkg::ST_TIMEOUT;
				end else if (!ready_q) begin
					status = measuring_q ? uer_pkg::ST_BUSY : uer_pkg::ST_NO_DATA;
				end else begin
					ok_read = 1'b1;
					ready_d = 1'b0;
				end
			end
			uer_pkg::MODE_CLEAR: begin
				start_time_d  = '0;
				pulse_width_d = '0;
				ready_d       = 1'b0;
				wrap_seen_d   = 1'b0;
				timed_out_d   = 1'b0;
				measuring_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Measurement state, updated once per request leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= uer_pkg::TIMEOUT_RESET;
			start_time_q   <= '0;
			pulse_width_q  <= '0;
			trigger_time_q <= '0;
			measuring_q    <= 1'b0;
			ready_q        <= 1'b0;
			wrap_seen_q    <= 1'b0;
			timed_out_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (advance && item_valid) begin
				start_time_q   <= start_time_d;
				pulse_width_q  <= pulse_width_d;
				trigger_time_q <= trigger_time_d;
				measuring_q    <= measuring_d;
				ready_q        <= ready_d;
				wrap_seen_q    <= wrap_seen_d;
				timed_out_q    <= timed_out_d;
			end
		end
	end

	// Result register; the scaled width is zero unless the read succeeded.
	always_ff @(posedge clk) begin
		if (advance) begin
			mid_s2.status        <= status;
			mid_s2.echo_time_us  <= ok_read ? pulse_width_q : 32'd0;
			mid_s2.scaled        <= ok_read ? product[31:0] : 32'd0;
			mid_s2.wrapped       <= wrap_seen_d;
			mid_s2.trigger_pulse <= pulse;
			mid_s2.busy_flag     <= measuring_d;
			mid_s2.ready_flag    <= ready_d;
		end
	end

endmodule

FILE: rtl/uer_dist.sv
module uer_dist (
	input  logic          clk,
	input  logic          advance,
	input  uer_pkg::mid_t mid_s2,
	output uer_pkg::res_t res_s3
);

	logic [56:0] quot_full;

	// Divide by 16 with a shift, then by 125 with a reciprocal multiply.
	assign quot_full = mid_s2.scaled[31:4] * uer_pkg::DIV_RECIP;

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s3.status        <= mid_s2.status;
			res_s3.echo_time_us  <= mid_s2.echo_time_us;
			res_s3.range_mm      <= quot_full[uer_pkg::DIV_SHIFT +: 22];
			res_s3.wrapped       <= mid_s2.wrapped;
			res_s3.trigger_pulse <= mid_s2.trigger_pulse;
			res_s3.busy_flag     <= mid_s2.busy_flag;
			res_s3.ready_flag    <= mid_s2.ready_flag;
		end
	end

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger controller.
// Requests arrive on the req channel (mode, echo level, microsecond and
// millisecond counts) and each request yields exactly one result on the res
// channel: read status, echo width, distance in millimeters and the flags.
// The timeout limit in milliseconds is written through cfg_we and cfg_wdata
// while no request is in flight; this binds the user, and the block itself
// does not enforce it. The limit resets to 100. A request passes three
// register stages: the input register, the control stage that updates the
// measurement state, and the distance stage whose reciprocal multiply
// divides by 2000. One request is taken every cycle unless the output stalls.
// When the receiver stalls, all stages hold and req.ready drops only while
// the output register is full and not taken.
// Reset clears all flags, times and the pipeline, and sets the limit to 100.
module ultrasonic_echo_ranger (
	input  logic        clk,
	input  logic        arst_n,
	uer_req_if.sink     req,
	uer_res_if.source   res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic          advance;
	logic          v_s1;
	logic          v_s2;
	logic          v_s3;
	uer_pkg::req_t item_s1;
	uer_pkg::mid_t mid_s2;
	uer_pkg::res_t res_s3;

	// The pipeline moves whenever the output register is free or taken.
	assign advance   = !v_s3 || res.ready;
	assign req.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1.mode       <= req.mode;
			item_s1.echo_level <= req.echo_level;
			item_s1.now_us     <= req.now_us;
			item_s1.now_ms     <= req.now_ms;
		end
	end

	uer_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item_valid (v_s1),
		.item       (item_s1),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mid_s2     (mid_s2)
	);

	uer_dist u_dist (
		.clk     (clk),
		.advance (advance),
		.mid_s2  (mid_s2),
		.res_s3  (res_s3)
	);

	// Output channel.
	assign res.valid         = v_s3;
	assign res.status        = res_s3.status;
	assign res.echo_time_us  = res_s3.echo_time_us;
	assign res.range_mm      = res_s3.range_mm;
	assign res.wrapped       = res_s3.wrapped;
	assign res.trigger_pulse = res_s3.trigger_pulse;
	assign res.busy_flag     = res_s3.busy_flag;
	assign res.ready_flag    = res_s3.ready_flag;

endmodule

FILE: sim/echo_ranger_checker.sv
module echo_ranger_checker (
	input  logic        clk,
	input  logic        arst_n,
	uer_req_if          req,
	uer_res_if          res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          mismatch_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import uer_pkg::*;

	localparam logic [31:0] MM_DIVISOR = 32'd2000;

	// Shadow copy of the ranger state and its timeout setting.
	logic [15:0] limit_ms;
	logic [31:0] start_us;
	logic [31:0] width_us;
	logic [31:0] trig_ms;
	logic        measuring;
	logic        result_held;
	logic        wrap_seen;
	logic        timed_out;

	res_t        expected_q[$];
	res_t        got;
	res_t        want;
	int          errs;

	function void clear_measurement();
		start_us    = '0;
		width_us    = '0;
		result_held = 1'b0;
		wrap_seen   = 1'b0;
		timed_out   = 1'b0;
	endfunction

	// Applies one request to the shadow state and returns the result it yields.
	function res_t ranger_result(input logic [2:0] mode, input logic level,
		input logic [31:0] us_raw, input logic [31:0] ms);
		res_t        r;
		logic [31:0] us;
		logic [31:0] scaled;
		r  = '0;
		us = us_raw & TIMER_MASK;
		case (mode)
		MODE_TRIGGER: begin
			if (!measuring) begin
				clear_measurement();
				measuring       = 1'b1;
				trig_ms         = ms;
				r.trigger_pulse = 1'b1;
			end
		end
		MODE_EDGE: begin
			if (measuring) begin
				if (level) begin
					start_us = us;
				end else begin
					if (us < start_us)
						wrap_seen = 1'b1;
					width_us    = (us - start_us) & TIMER_MASK;
					result_held = 1'b1;
					measuring   = 1'b0;
				end
			end
		end
		MODE_TICK: begin
			if (measuring && (ms - trig_ms) > 32'(limit_ms)) begin
				timed_out = 1'b1;
				measuring = 1'b0;
			end
		end
		MODE_READ: begin
			if (timed_out) begin
				timed_out = 1'b0;
				r.status  = ST_TIMEOUT;
			end else if (!result_held) begin
				r.status = measuring ? ST_BUSY : ST_NO_DATA;
			end else begin
				// The product wraps at 32 bits before the division.
				scaled         = width_us * 32'(SOUND_NUM);
				r.status       = ST_OK;
				r.echo_time_us = width_us;
				r.range_mm     = 22'(scaled / MM_DIVISOR);
				result_held    = 1'b0;
			end
		end
		MODE_CLEAR: begin
			clear_measurement();
			measuring = 1'b0;
		end
		default: begin
		end
		endcase
		r.wrapped    = wrap_seen;
		r.busy_flag  = measuring;
		r.ready_flag = result_held;
		return r;
	endfunction

	// Watch both channels: compare each result, then predict each new request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_ms  = TIMEOUT_RESET;
			trig_ms   = '0;
			measuring = 1'b0;
			clear_measurement();
			expected_q.delete();
			errs = 0;
			mismatch_count <= 0;
			pending_count  <= 0;
		end else begin
			if (cfg_we)
				limit_ms = cfg_wdata;

			if (res.valid && res.ready) begin
				got.status        = res.status;
				got.echo_time_us  = res.echo_time_us;
				got.range_mm      = res.range_mm;
				got.wrapped       = res.wrapped;
				got.trigger_pulse = res.trigger_pulse;
				got.busy_flag     = res.busy_flag;
				got.ready_flag    = res.ready_flag;
				if (expected_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%t: result with no request outstanding, status %0d",
							$realtime, got.status);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10) begin
							$display("%t: result mismatch", $realtime);
							$display("  expected st=%0d us=%0d mm=%0d wrap=%b trig=%b busy=%b rdy=%b",
								want.status, want.echo_time_us, want.range_mm,
								want.wrapped, want.trigger_pulse, want.busy_flag,
								want.ready_flag);
							$display("  actual   st=%0d us=%0d mm=%0d wrap=%b trig=%b busy=%b rdy=%b",
								got.status, got.echo_time_us, got.range_mm,
								got.wrapped, got.trigger_pulse, got.busy_flag,
								got.ready_flag);
						end
					end
				end
			end

			if (req.valid && req.ready)
				expected_q.push_back(ranger_result(req.mode, req.echo_level,
					req.now_us, req.now_ms));

			mismatch_count <= errs;
			pending_count  <= expected_q.size();
		end
	end

endmodule

FILE: sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import uer_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	uer_req_if req_ch();
	uer_res_if res_ch();

	int mismatch_count;
	int pending_count;

	// Stimulus control shared with the receiver process.
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        hold_off;
	bit          hold_used;
	logic [15:0] limit_now;
	logic [31:0] us_now;
	logic [31:0] ms_now;
	int          sent;

	ultrasonic_echo_ranger u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	echo_ranger_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.res            (res_ch),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one request, possibly after a random gap, and wait for it to be taken.
	task automatic send_req(input logic [2:0] mode, input logic level,
		input logic [31:0] us, input logic [31:0] ms);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= mode;
		req_ch.echo_level <= level;
		req_ch.now_us     <= us;
		req_ch.now_ms     <= ms;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// Stop offering and wait until every outstanding result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_now = value;
	endtask

	// Millisecond advance: often small, sometimes at or one past the timeout limit.
	function automatic logic [31:0] next_ms_step();
		case ($urandom_range(7))
		0: return 32'(limit_now) + 32'd1;
		1: return 32'(limit_now);
		2: return $urandom();
		3: return $urandom_range(32'(limit_now) + 2);
		default: return $urandom_range(3);
		endcase
	endfunction

	// One well-formed measurement with random timing, reads and interruptions.
	task automatic measure_cycle();
		logic [31:0] width;
		case ($urandom_range(9))
		0: width = $urandom();
		1: width = '0;
		default: width = $urandom_range(30000, 1);
		endcase
		ms_now += $urandom_range(5);
		send_req(MODE_TRIGGER, 1'($urandom_range(1)), $urandom(), ms_now);
		if ($urandom_range(2) == 0) begin
			ms_now += next_ms_step();
			send_req(MODE_TICK, 1'($urandom_range(1)), $urandom(), ms_now);
		end
		if ($urandom_range(3) == 0)
			us_now = 32'hFFFF_FFFF - $urandom_range(50);
		else
			us_now = $urandom();
		send_req(MODE_EDGE, 1'b1, us_now, $urandom());
		if ($urandom_range(7) == 0) begin
			us_now += $urandom_range(100);
			send_req(MODE_EDGE, 1'b1, us_now, $urandom());
		end
		if ($urandom_range(3) == 0)
			send_req(MODE_READ, 1'($urandom_range(1)), $urandom(), $urandom());
		if ($urandom_range(3) == 0) begin
			ms_now += next_ms_step();
			send_req(MODE_TICK, 1'($urandom_range(1)), $urandom(), ms_now);
		end
		us_now += width;
		send_req(MODE_EDGE, 1'b0, us_now, $urandom());
		if ($urandom_range(9) == 0)
			send_req(MODE_CLEAR, 1'($urandom_range(1)), $urandom(), $urandom());
		repeat ($urandom_range(2, 1))
			send_req(MODE_READ, 1'($urandom_range(1)), $urandom(), $urandom());
	endtask

	task automatic run_random(input int count);
		int target;
		target = sent + count;
		while (sent < target) begin
			if ($urandom_range(9) < 8)
				measure_cycle();
			else
				send_req(3'($urandom_range(7)), 1'($urandom_range(1)), $urandom(),
					$urandom());
		end
	endtask

	// Result side: random stalls, plus one long hold-off that backs up the pipe.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off && !hold_used) begin
				hold_used = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (40) @(posedge clk);
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#5ms;
		$display("FAIL ultrasonic_echo_ranger");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = MODE_TRIGGER;
		req_ch.echo_level = 1'b0;
		req_ch.now_us     = '0;
		req_ch.now_ms     = '0;
		hold_off          = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		limit_now         = TIMEOUT_RESET;
		us_now            = $urandom();
		ms_now            = $urandom();
		sent              = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests with the reset timeout of 100 ms.
		send_req(MODE_READ, 1'b0, '0, '0);
		send_req(MODE_TICK, 1'b1, '1, '1);
		send_req(MODE_EDGE, 1'b1, '1, '0);
		send_req(MODE_EDGE, 1'b0, '0, '0);
		send_req(MODE_TRIGGER, 1'b0, '0, 32'hFFFF_FFF0);
		send_req(MODE_TRIGGER, 1'b1, '1, '0);
		send_req(MODE_READ, 1'b0, '0, '0);
		// Elapsed time across the millisecond wrap: exactly the limit, then one past.
		send_req(MODE_TICK, 1'b0, '0, 32'h0000_0054);
		send_req(MODE_TICK, 1'b0, '0, 32'h0000_0055);
		send_req(MODE_READ, 1'b0, '0, '0);
		send_req(MODE_READ, 1'b0, '0, '0);
		// Echo across the microsecond wrap, then a full-scale width.
		send_req(MODE_TRIGGER, 1'b0, '0, 32'd5);
		send_req(MODE_EDGE, 1'b1, 32'hFFFF_FFF5, '0);
		send_req(MODE_EDGE, 1'b0, 32'd20, '0);
		send_req(MODE_READ, 1'b0, '0, '0);
		send_req(MODE_READ, 1'b0, '0, '0);
		send_req(MODE_TRIGGER, 1'b0, '0, 32'd6);
		send_req(MODE_EDGE, 1'b1, '0, '0);
		send_req(MODE_EDGE, 1'b0, '1, '1);
		send_req(MODE_READ, 1'b1, '1, '1);
		send_req(MODE_TRIGGER, 1'b1, '1, '1);
		send_req(MODE_CLEAR, 1'b0, '0, '0);
		for (int m = int'(MODE_CLEAR) + 1; m < 8; m++)
			send_req(3'(m), 1'b1, '1, '1);

		// Random phases, each with its own timeout setting and idling pattern.
		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
			0: begin
				write_limit(16'hFFFF);
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				hold_off <= 1'b1;
			end
			1: begin
				write_limit(16'h0000);
				send_idle_pct  = 46;
				recv_stall_pct = 0;
			end
			2: begin
				write_limit(16'($urandom_range(200, 2)));
				send_idle_pct  = 0;
				recv_stall_pct = 46;
			end
			default: begin
				write_limit(16'd1);
				send_idle_pct  = 10;
				recv_stall_pct = 10;
			end
			endcase
			run_random(356);
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("PASS ultrasonic_echo_ranger");
		else
			$display("FAIL ultrasonic_echo_ranger");
		$finish;
	end

endmodule

FILE: sim.f
rtl/uer_pkg.sv
rtl/uer_req_if.sv
rtl/uer_res_if.sv
rtl/uer_ctrl.sv
rtl/uer_dist.sv
rtl/ultrasonic_echo_ranger.sv
sim/echo_ranger_checker.sv
sim/tb_top.sv
